[rtl/gnc_pkg.sv]
// ----------------------------------------------------------------------------
// gnc_pkg
// Shared constants and types of the 3x3 neighbour count block.
// ----------------------------------------------------------------------------
package gnc_pkg;

   // default sizing of the line history and the row counter
   localparam int MAX_WIDTH_DEF  = 32;
   localparam int MAX_HEIGHT_DEF = 1024;

   // the end-of-frame flush gives width + 2 results, so width tops out here
   localparam int WIDTH_CAP = 31;

   localparam int GRID_WIDTH_W    = 6;
   localparam int GRID_HEIGHT_W   = 11;
   localparam int GRID_WIDTH_RST  = 26;
   localparam int GRID_HEIGHT_RST = 10;

   localparam int NCOUNT_W   = 4;
   localparam int CSR_DATA_W = 11;

   typedef enum logic [0:0] {
      CSR_GRID_WIDTH  = 1'b0,
      CSR_GRID_HEIGHT = 1'b1
   } csr_index_type;

   typedef logic [NCOUNT_W-1:0]   ncount_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;

endpackage

[rtl/gnc_if.sv]
// ----------------------------------------------------------------------------
// gnc interfaces
// Valid/ready channels for cell input, count results and register writes.
// ----------------------------------------------------------------------------
interface gnc_req_if;
   logic valid;
   logic ready;
   logic cell_bit;

   modport source (output valid, output cell_bit, input ready);
   modport sink   (input valid, input cell_bit, output ready);
endinterface

interface gnc_rsp_if;
   import gnc_pkg::*;
   logic       valid;
   logic       ready;
   ncount_type neighbour_count;
   logic       cell_value;
   logic       frame_last;

   modport source (output valid, output neighbour_count, output cell_value,
                   output frame_last, input ready);
   modport sink   (input valid, input neighbour_count, input cell_value,
                   input frame_last, output ready);
endinterface

interface gnc_csr_if;
   import gnc_pkg::*;
   logic          valid;
   logic          ready;
   csr_index_type index;
   csr_data_type  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/gnc_front.sv]
// ----------------------------------------------------------------------------
// gnc_front
// Accepts cells, keeps the line history and raster position, and queues one
// job per result run: a single result, or the end-of-frame flush.
// ----------------------------------------------------------------------------
module gnc_front #(
   parameter int MAX_WIDTH  = gnc_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = gnc_pkg::MAX_HEIGHT_DEF
) (
   input  logic clock,
   input  logic reset,
   gnc_req_if.sink req_chan,
   input  logic [$clog2(((MAX_WIDTH < gnc_pkg::WIDTH_CAP) ? MAX_WIDTH
                         : gnc_pkg::WIDTH_CAP) + 2)-1:0] eff_w,
   input  logic [$clog2(MAX_HEIGHT+1)-1:0] eff_h,
   input  logic job_full,
   output logic job_push,
   output logic [2*MAX_WIDTH+3+$clog2(MAX_HEIGHT)
                 +$clog2((MAX_WIDTH < gnc_pkg::WIDTH_CAP) ? MAX_WIDTH : gnc_pkg::WIDTH_CAP)
                 +$clog2(((MAX_WIDTH < gnc_pkg::WIDTH_CAP) ? MAX_WIDTH
                          : gnc_pkg::WIDTH_CAP) + 2)+1-1:0] job_data
);
   import gnc_pkg::*;

   localparam int W_CAP = (MAX_WIDTH < WIDTH_CAP) ? MAX_WIDTH : WIDTH_CAP;
   localparam int COL_W = $clog2(W_CAP);
   localparam int WV_W  = $clog2(W_CAP + 2);
   localparam int ROW_W = $clog2(MAX_HEIGHT);
   localparam int HIST  = 2 * MAX_WIDTH + 2;

   logic [HIST-1:0]  hist_ff, hist_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;

   logic [COL_W-1:0] col_lim, col_c, job_rx;
   logic [ROW_W-1:0] row_lim, row_c, job_ry;
   logic [WV_W-1:0]  job_left;
   logic             at_last, has_rsp, accept;

   assign req_chan.ready = !job_full;
   assign accept         = req_chan.valid && req_chan.ready;

   assign col_lim = COL_W'(eff_w - WV_W'(1));
   assign row_lim = ROW_W'(eff_h - 1'b1);
   assign col_c   = (col_ff > col_lim) ? col_lim : col_ff;
   assign row_c   = (row_ff > row_lim) ? row_lim : row_ff;
   assign at_last = (row_c == row_lim) && (col_c == col_lim);
   assign has_rsp = (32'(row_c) >= 2) || ((32'(row_c) == 1) && (col_c != '0));

   always_comb begin
      if (at_last) begin
         // flush starts one row plus one cell back
         job_ry   = row_lim - ROW_W'(1);
         job_rx   = col_lim - COL_W'(1);
         job_left = eff_w + WV_W'(1);
      end else if (col_c != '0) begin
         job_ry   = row_c - ROW_W'(1);
         job_rx   = col_c - COL_W'(1);
         job_left = '0;
      end else begin
         job_ry   = row_c - ROW_W'(2);
         job_rx   = col_lim;
         job_left = '0;
      end
   end

   assign job_push = accept && (at_last || has_rsp);
   assign job_data = {hist_ff, req_chan.cell_bit, job_ry, job_rx, job_left, at_last};

   always_comb begin
      hist_in = hist_ff;
      col_in  = col_ff;
      row_in  = row_ff;
      if (accept) begin
         hist_in = {hist_ff[HIST-2:0], req_chan.cell_bit};
         if (at_last) begin
            col_in = '0;
            row_in = '0;
         end else if (col_c >= col_lim) begin
            col_in = '0;
            row_in = row_c + ROW_W'(1);
         end else begin
            col_in = col_c + COL_W'(1);
            row_in = row_c;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff <= '0;
         col_ff  <= '0;
         row_ff  <= '0;
      end else begin
         hist_ff <= hist_in;
         col_ff  <= col_in;
         row_ff  <= row_in;
      end
   end

endmodule

[rtl/gnc_fifo.sv]
// ----------------------------------------------------------------------------
// gnc_fifo
// Short show-ahead job queue between the front and the back.
// ----------------------------------------------------------------------------
module gnc_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   import gnc_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;

   assign full     = (fill_ff == CNT_W'(DEPTH));
   assign empty    = (fill_ff == '0);
   assign pop_data = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + CNT_W'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("gnc_fifo: push while full");
   assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("gnc_fifo: pop while empty");
   assert property (@(posedge clock) disable iff (reset) fill_ff <= CNT_W'(DEPTH))
      else $error("gnc_fifo: fill level above depth");

endmodule

[rtl/gnc_back.sv]
// ----------------------------------------------------------------------------
// gnc_back
// Takes queued jobs and, unless rsp_chan stalls, makes one count result per
// cycle from a frozen window of the cell history, stepping it for a flush.
// ----------------------------------------------------------------------------
module gnc_back #(
   parameter int MAX_WIDTH  = gnc_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = gnc_pkg::MAX_HEIGHT_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic [$clog2(((MAX_WIDTH < gnc_pkg::WIDTH_CAP) ? MAX_WIDTH
                         : gnc_pkg::WIDTH_CAP) + 2)-1:0] eff_w,
   input  logic [$clog2(MAX_HEIGHT+1)-1:0] eff_h,
   input  logic job_empty,
   output logic job_pop,
   input  logic [2*MAX_WIDTH+3+$clog2(MAX_HEIGHT)
                 +$clog2((MAX_WIDTH < gnc_pkg::WIDTH_CAP) ? MAX_WIDTH : gnc_pkg::WIDTH_CAP)
                 +$clog2(((MAX_WIDTH < gnc_pkg::WIDTH_CAP) ? MAX_WIDTH
                          : gnc_pkg::WIDTH_CAP) + 2)+1-1:0] job_data,
   gnc_rsp_if.source rsp_chan
);
   import gnc_pkg::*;

   localparam int W_CAP = (MAX_WIDTH < WIDTH_CAP) ? MAX_WIDTH : WIDTH_CAP;
   localparam int COL_W = $clog2(W_CAP);
   localparam int WV_W  = $clog2(W_CAP + 2);
   localparam int ROW_W = $clog2(MAX_HEIGHT);
   localparam int HV_W  = $clog2(MAX_HEIGHT + 1);
   localparam int WIN_W = 2 * MAX_WIDTH + 3;
   localparam int IDX_W = $clog2(WIN_W);

   // window bit d holds the cell d places before the newest one
   logic [WIN_W-1:0] win_ff, win_in, job_win;
   logic [ROW_W-1:0] ry_ff, ry_in, job_ry;
   logic [COL_W-1:0] rx_ff, rx_in, job_rx, col_lim;
   logic [WV_W-1:0]  left_ff, left_in, job_left;
   logic             last_ff, last_in, job_last;
   logic             busy_ff, busy_in;

   logic             rsp_valid_ff, rsp_valid_in;
   ncount_type       count_ff, count;
   logic             cell_ff, last_out_ff;

   logic [IDX_W-1:0] d_w, d_w1, d_w2, d_2w, d_2w1, d_2w2;
   logic             up_ok, dn_ok, lf_ok, rt_ok;
   logic [7:0]       nb;
   logic             out_free, fire, done;

   assign {job_win, job_ry, job_rx, job_left, job_last} = job_data;

   assign col_lim = COL_W'(eff_w - WV_W'(1));

   // tap offsets follow the row width
   assign d_w   = IDX_W'(eff_w);
   assign d_w1  = d_w + IDX_W'(1);
   assign d_w2  = d_w + IDX_W'(2);
   assign d_2w  = {d_w[IDX_W-2:0], 1'b0};
   assign d_2w1 = d_2w + IDX_W'(1);
   assign d_2w2 = d_2w + IDX_W'(2);

   assign up_ok = (ry_ff != '0);
   assign dn_ok = (HV_W'(ry_ff) + HV_W'(1)) < eff_h;
   assign lf_ok = (rx_ff != '0);
   assign rt_ok = (WV_W'(rx_ff) + WV_W'(1)) < eff_w;

   assign nb[0] = win_ff[d_2w2] && up_ok && lf_ok;
   assign nb[1] = win_ff[d_2w1] && up_ok;
   assign nb[2] = win_ff[d_2w]  && up_ok && rt_ok;
   assign nb[3] = win_ff[d_w2]  && lf_ok;
   assign nb[4] = win_ff[d_w]   && rt_ok;
   assign nb[5] = win_ff[2]     && dn_ok && lf_ok;
   assign nb[6] = win_ff[1]     && dn_ok;
   assign nb[7] = win_ff[0]     && dn_ok && rt_ok;

   always_comb begin
      count = '0;
      for (int i = 0; i < 8; i++) begin
         count = count + NCOUNT_W'(nb[i]);
      end
   end

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign fire     = busy_ff && out_free;
   assign done     = fire && (left_ff == '0);
   assign job_pop  = !job_empty && (!busy_ff || done);

   always_comb begin
      win_in  = win_ff;
      ry_in   = ry_ff;
      rx_in   = rx_ff;
      left_in = left_ff;
      last_in = last_ff;
      busy_in = busy_ff;
      if (job_pop) begin
         win_in  = job_win;
         ry_in   = job_ry;
         rx_in   = job_rx;
         left_in = job_left;
         last_in = job_last;
         busy_in = 1'b1;
      end else if (done) begin
         busy_in = 1'b0;
      end else if (fire) begin
         // advance to the next cell of the flush
         win_in  = {win_ff[WIN_W-2:0], 1'b0};
         left_in = left_ff - WV_W'(1);
         if (rx_ff == col_lim) begin
            rx_in = '0;
            ry_in = ry_ff + ROW_W'(1);
         end else begin
            rx_in = rx_ff + COL_W'(1);
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff  <= win_in;
      ry_ff   <= ry_in;
      rx_ff   <= rx_in;
      left_ff <= left_in;
      last_ff <= last_in;
      if (fire) begin
         count_ff    <= count;
         cell_ff     <= win_ff[d_w1];
         last_out_ff <= last_ff && (left_ff == '0);
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.neighbour_count = count_ff;
   assign rsp_chan.cell_value      = cell_ff;
   assign rsp_chan.frame_last      = last_out_ff;

   assert property (@(posedge clock) disable iff (reset) job_pop |-> !job_empty)
      else $error("gnc_back: job taken from an empty queue");
   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid_ff |-> (count_ff <= NCOUNT_W'(8)))
      else $error("gnc_back: neighbour count above eight");
   assert property (@(posedge clock) disable iff (reset)
                    (fire && (left_ff != '0)) |=> busy_ff)
      else $error("gnc_back: flush dropped before its last result");
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_valid_ff && !rsp_chan.ready) |-> !fire)
      else $error("gnc_back: result overwritten while stalled");

endmodule

[rtl/grid_neighbour_count_3x3_core.sv]
// ----------------------------------------------------------------------------
// grid_neighbour_count_3x3_core
// Counts set cells in the 3x3 neighbourhood of every cell of a binary grid.
// ----------------------------------------------------------------------------
// Cells enter on req_chan, one bit per item, in raster order. Each result on
// rsp_chan carries the number of set neighbours (0..8), the cell's own bit,
// and frame_last on the result for the final cell of the frame. Cells
// outside the grid count as clear.
// Results trail the input by one row plus one cell: the result for a cell
// is made when the cell one row and one cell later is accepted, and then
// passes through the job queue and the result registers to rsp_chan. The
// last cell of a frame releases the remaining width + 2 results, one per
// cycle while rsp_chan is not stalled. Throughput is one item per cycle;
// input is held off only once the two-entry job queue fills behind the
// end-of-frame flush or a stalled rsp_chan.
// csr_chan writes grid_width (index 0) and grid_height (index 1); write
// them only between items with no result pending. Width is held to
// 2..min(MAX_WIDTH, 31), height to 2..MAX_HEIGHT.
// Reset clears the history, the raster position and the queue, and loads
// width 26 and height 10. A stalled rsp_chan holds its result steady.
// ----------------------------------------------------------------------------
module grid_neighbour_count_3x3_core #(
   parameter int MAX_WIDTH  = gnc_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = gnc_pkg::MAX_HEIGHT_DEF
) (
   input  logic clock,
   input  logic reset,
   gnc_req_if.sink   req_chan,
   gnc_rsp_if.source rsp_chan,
   gnc_csr_if.sink   csr_chan
);
   import gnc_pkg::*;

   localparam int W_CAP = (MAX_WIDTH < WIDTH_CAP) ? MAX_WIDTH : WIDTH_CAP;
   localparam int COL_W = $clog2(W_CAP);
   localparam int WV_W  = $clog2(W_CAP + 2);
   localparam int ROW_W = $clog2(MAX_HEIGHT);
   localparam int HV_W  = $clog2(MAX_HEIGHT + 1);
   localparam int JOB_W = 2 * MAX_WIDTH + 3 + ROW_W + COL_W + WV_W + 1;

   logic [GRID_WIDTH_W-1:0]  grid_width_ff, grid_width_in;
   logic [GRID_HEIGHT_W-1:0] grid_height_ff, grid_height_in;
   logic [WV_W-1:0]          eff_w;
   logic [HV_W-1:0]          eff_h;

   logic             push, full, pop, empty;
   logic [JOB_W-1:0] push_data, pop_data;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      grid_width_in  = grid_width_ff;
      grid_height_in = grid_height_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_GRID_WIDTH:  grid_width_in  = csr_chan.data[GRID_WIDTH_W-1:0];
            CSR_GRID_HEIGHT: grid_height_in = csr_chan.data[GRID_HEIGHT_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= GRID_WIDTH_W'(GRID_WIDTH_RST);
         grid_height_ff <= GRID_HEIGHT_W'(GRID_HEIGHT_RST);
      end else begin
         grid_width_ff  <= grid_width_in;
         grid_height_ff <= grid_height_in;
      end
   end

   // clamp the registers to the supported frame size
   always_comb begin
      if (32'(grid_width_ff) < 2) begin
         eff_w = WV_W'(2);
      end else if (32'(grid_width_ff) > W_CAP) begin
         eff_w = WV_W'(W_CAP);
      end else begin
         eff_w = WV_W'(grid_width_ff);
      end
      if (32'(grid_height_ff) < 2) begin
         eff_h = HV_W'(2);
      end else if (32'(grid_height_ff) > MAX_HEIGHT) begin
         eff_h = HV_W'(MAX_HEIGHT);
      end else begin
         eff_h = HV_W'(grid_height_ff);
      end
   end

   gnc_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .eff_w    (eff_w),
      .eff_h    (eff_h),
      .job_full (full),
      .job_push (push),
      .job_data (push_data)
   );

   gnc_fifo #(
      .WIDTH (JOB_W),
      .DEPTH (2)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (empty)
   );

   gnc_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .eff_w     (eff_w),
      .eff_h     (eff_h),
      .job_empty (empty),
      .job_pop   (pop),
      .job_data  (pop_data),
      .rsp_chan  (rsp_chan)
   );

endmodule

[dv/tb_grid_neighbour_count_3x3_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grid_neighbour_count_3x3_core
// Streams binary grids into the neighbour count core and checks each count
// result against a cycle-free prediction of the 3x3 window. This includes
// grid clamping, resizing inside a frame, end-of-frame flushes and back
// pressure on both channels.
// ----------------------------------------------------------------------------
module tb_grid_neighbour_count_3x3_core;
   import gnc_pkg::*;

   localparam int HIST_LEN      = 2 * MAX_WIDTH_DEF + 2;
   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_CELLS  = 20;

   typedef struct packed {
      ncount_type count;
      logic       value;
      logic       last;
   } count_result_type;

   logic clock;
   logic reset;

   gnc_req_if req_if();
   gnc_rsp_if rsp_if();
   gnc_csr_if csr_if();

   grid_neighbour_count_3x3_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   // predicted block state
   logic [GRID_WIDTH_W-1:0]  width_reg  = GRID_WIDTH_W'(GRID_WIDTH_RST);
   logic [GRID_HEIGHT_W-1:0] height_reg = GRID_HEIGHT_W'(GRID_HEIGHT_RST);
   logic [HIST_LEN-1:0]      history    = '0;
   int                       col_pos    = 0;
   int                       row_pos    = 0;
   count_result_type         pending_counts[$];

   int error_count     = 0;
   int cycle_count     = 0;
   int hold_rsp_cycles = 0;
   bit req_gaps        = 1'b1;
   bit rsp_gaps        = 1'b1;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      while (cycle_count <= CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Verification failed");
      $finish;
   end

   function automatic int used_width();
      int w;
      w = width_reg;
      if (w < 2) w = 2;
      if (w > WIDTH_CAP) w = WIDTH_CAP;
      if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
      return w;
   endfunction

   function automatic int used_height();
      int h;
      h = height_reg;
      if (h < 2) h = 2;
      if (h > MAX_HEIGHT_DEF) h = MAX_HEIGHT_DEF;
      return h;
   endfunction

   // bit of frame cell q while cell p (bit cur) is being taken
   function automatic logic bit_of(input int q, input int p, input logic cur);
      if (q > p) return 1'b0;
      if (q == p) return cur;
      if (p - q > HIST_LEN) return 1'b0;
      return history[p - q - 1];
   endfunction

   function automatic count_result_type result_for(input int r, input int p, input logic cur,
                                                   input int w, input int h, input bit last);
      count_result_type res;
      int ry, rx, ny, nx, dy, dx, cnt;
      ry  = r / w;
      rx  = r % w;
      cnt = 0;
      for (dy = -1; dy <= 1; dy++) begin
         for (dx = -1; dx <= 1; dx++) begin
            ny = ry + dy;
            nx = rx + dx;
            // cells off the grid count as clear
            if ((dy != 0 || dx != 0) && ny >= 0 && nx >= 0 && ny < h && nx < w)
               cnt += bit_of(ny * w + nx, p, cur);
         end
      end
      res.count = ncount_type'(cnt);
      res.value = bit_of(r, p, cur);
      res.last  = last && (r == p);
      return res;
   endfunction

   function automatic void count_cell(input logic cur);
      int w, h, col, row, p, r;
      bit last;
      w   = used_width();
      h   = used_height();
      col = col_pos;
      row = row_pos;
      // a position left beyond a shrunk grid sits on the last column or row
      if (col > w - 1) col = w - 1;
      if (row > h - 1) row = h - 1;
      p    = row * w + col;
      last = (row == h - 1) && (col == w - 1);
      if (last) begin
         for (r = p - w - 1; r <= p; r++)
            pending_counts.push_back(result_for(r, p, cur, w, h, 1'b1));
      end else if (p >= w + 1) begin
         pending_counts.push_back(result_for(p - w - 1, p, cur, w, h, 1'b0));
      end
      history = {history[HIST_LEN-2:0], cur};
      if (last) begin
         col_pos = 0;
         row_pos = 0;
      end else if (col >= w - 1) begin
         col_pos = 0;
         row_pos = row + 1;
      end else begin
         col_pos = col + 1;
         row_pos = row;
      end
   endfunction

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= 40)
         $display("%0t ns mismatch: %s", $realtime, what);
   endtask

   // result side: check every accepted item, then pick ready for the next edge
   initial begin : result_checker
      count_result_type want;
      int stall_left;
      stall_left   = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            if (pending_counts.size() == 0) begin
               report_mismatch($sformatf("unexpected result, count %0d value %0b last %0b",
                  rsp_if.neighbour_count, rsp_if.cell_value, rsp_if.frame_last));
            end else begin
               want = pending_counts.pop_front();
               if (rsp_if.neighbour_count !== want.count)
                  report_mismatch($sformatf("neighbour_count %0d, want %0d",
                     rsp_if.neighbour_count, want.count));
               if (rsp_if.cell_value !== want.value)
                  report_mismatch($sformatf("cell_value %0b, want %0b",
                     rsp_if.cell_value, want.value));
               if (rsp_if.frame_last !== want.last)
                  report_mismatch($sformatf("frame_last %0b, want %0b",
                     rsp_if.frame_last, want.last));
            end
         end
         if (hold_rsp_cycles > 0) begin
            hold_rsp_cycles--;
            rsp_if.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else if (rsp_gaps && $urandom_range(0, 11) == 0) begin
            stall_left = $urandom_range(1, 19) - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   task automatic send_cell(input logic cell_val);
      if (req_gaps && $urandom_range(0, 7) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.cell_bit <= cell_val;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      count_cell(cell_val);
   endtask

   // density in quarters: 0 gives all clear, 4 all set
   task automatic send_cells(input int n, input int density);
      repeat (n) send_cell($urandom_range(0, 3) < density);
   endtask

   task automatic finish_frame(input int density);
      do
         send_cell($urandom_range(0, 3) < density);
      while (col_pos != 0 || row_pos != 0);
   endtask

   // hold input until every expected item is back, then let the core settle
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_counts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input csr_data_type value);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      csr_if.valid <= 1'b0;
      if (idx == CSR_GRID_WIDTH)
         width_reg = value[GRID_WIDTH_W-1:0];
      else
         height_reg = value;
      @(posedge clock);
   endtask

   // first result must appear one row plus one cell in, under reset sizes
   task automatic test_reset_sizes();
      send_cells(GRID_WIDTH_RST + 2, 2);
      wait_drained();
   endtask

   // shrink the grid with the raster position part way through a row
   task automatic test_resize_mid_frame();
      write_reg(CSR_GRID_WIDTH, 3);
      write_reg(CSR_GRID_HEIGHT, 3);
      finish_frame(2);
      wait_drained();
   endtask

   task automatic test_smallest_grid();
      write_reg(CSR_GRID_WIDTH, 0);
      write_reg(CSR_GRID_HEIGHT, 1);
      finish_frame(4);
      wait_drained();
      write_reg(CSR_GRID_WIDTH, 1);
      write_reg(CSR_GRID_HEIGHT, 0);
      finish_frame(0);
      wait_drained();
   endtask

   task automatic test_corners_and_edges();
      int i;
      write_reg(CSR_GRID_WIDTH, 3);
      write_reg(CSR_GRID_HEIGHT, 3);
      finish_frame(4);
      // lone set cell in the middle: every border cell sees exactly one
      for (i = 0; i < 9; i++)
         send_cell(i == 4);
      wait_drained();
   endtask

   task automatic test_height_clamp();
      write_reg(CSR_GRID_WIDTH, 2);
      write_reg(CSR_GRID_HEIGHT, 11'h7FF);
      send_cells(6, 2);
      wait_drained();
      // row already past the new bottom, so it is taken as the last row and the frame ends there
      write_reg(CSR_GRID_HEIGHT, 0);
      finish_frame(3);
      wait_drained();
   endtask

   task automatic test_widest_row();
      write_reg(CSR_GRID_WIDTH, 11'h03F);
      write_reg(CSR_GRID_HEIGHT, 2);
      finish_frame(2);
      wait_drained();
      write_reg(CSR_GRID_WIDTH, 11'h7E0);
      finish_frame(4);
      wait_drained();
   endtask

   task automatic test_output_backpressure();
      write_reg(CSR_GRID_WIDTH, 4);
      write_reg(CSR_GRID_HEIGHT, 4);
      req_gaps = 1'b0;
      rsp_gaps = 1'b0;
      hold_rsp_cycles = 200;
      send_cells(16, 2);
      wait_drained();
      req_gaps = 1'b1;
      rsp_gaps = 1'b1;
   endtask

   task automatic test_random_frames();
      int sent, w_raw, h_raw, n;
      sent = 0;
      while (sent < RANDOM_CELLS) begin
         req_gaps = $urandom_range(0, 3) != 0;
         rsp_gaps = $urandom_range(0, 3) != 0;
         if ($urandom_range(0, 5) == 0) w_raw = $urandom_range(0, 63);
         else w_raw = $urandom_range(2, 8);
         if ($urandom_range(0, 7) == 0) h_raw = $urandom_range(0, 2047);
         else h_raw = $urandom_range(1, 5);
         // upper data bits are outside the width register and must be dropped
         write_reg(CSR_GRID_WIDTH, csr_data_type'(($urandom_range(0, 31) << 6) | w_raw));
         write_reg(CSR_GRID_HEIGHT, csr_data_type'(h_raw));
         if (used_width() * used_height() > 96)
            n = $urandom_range(1, 40);
         else
            n = used_width() * used_height() * $urandom_range(1, 2);
         if ($urandom_range(0, 4) == 0)
            n += $urandom_range(1, used_width());
         if (n > RANDOM_CELLS - sent)
            n = RANDOM_CELLS - sent;
         send_cells(n, $urandom_range(0, 4));
         sent += n;
         wait_drained();
      end
   endtask

   task automatic test_steady_stream();
      req_gaps = 1'b0;
      rsp_gaps = 1'b0;
      write_reg(CSR_GRID_WIDTH, 5);
      write_reg(CSR_GRID_HEIGHT, 3);
      finish_frame(2);
      finish_frame(3);
      wait_drained();
   endtask

   initial begin
      reset           = 1'b1;
      req_if.valid    = 1'b0;
      req_if.cell_bit = 1'b0;
      csr_if.valid    = 1'b0;
      csr_if.index    = CSR_GRID_WIDTH;
      csr_if.data     = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_sizes();
      test_resize_mid_frame();
      test_smallest_grid();
      test_corners_and_edges();
      test_height_clamp();
      test_widest_row();
      test_output_backpressure();
      test_random_frames();
      test_steady_stream();

      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
